FILE: sv/assert_macros.svh
// assertion macros shared by the tank level advert decoder
// no dependencies; taken in by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, sampled on the rising clock edge
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: sv/tlad_pkg.sv
// types, constants and register codes of the tank level advert decoder
// no dependencies; imported by every module of the block
`default_nettype none

package tlad_pkg;

	localparam int AddrW   = 48;
	localparam int MmW     = 14;
	localparam int PctW    = 7;
	localparam int PolyW   = 24;
	localparam int NumW    = 21;
	localparam int QuoW    = 7;
	localparam int CfgIdxW = 3;

	localparam logic [7:0]        PAYLOAD_BYTES = 8'd10;
	localparam logic [3:0]        RECORDS_OK    = 4'd1;
	localparam logic [PolyW:0]    COEF_C0       = 25'd9614100;
	localparam logic [22:0]       COEF_C1_MAG   = 23'd47345;
	localparam logic [PolyW:0]    COEF_C2_MAG   = 25'd90;
	localparam logic [10:0]       BAT_OFFSET    = 11'd704;
	localparam logic [MmW-1:0]    BAT_SCALE     = 14'd25;
	localparam logic [28:0]       BAT_RECIP     = 29'd20165;
	localparam int                BAT_SHIFT     = 20;
	localparam logic [PctW-1:0]   PCT_FULL      = 7'd100;
	localparam logic [7:0]        TEMP_OFFSET   = 8'd40;
	localparam logic [NumW-1:0]   LEVEL_SCALE   = 21'd100;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_ADDR  = 3'd1,
		ST_COUNT = 3'd2,
		ST_LEN   = 3'd3,
		ST_TYPE  = 3'd4
	} status_e;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEVICE_ADDRESS = 3'd0,
		REG_FULL_LEVEL     = 3'd1,
		REG_EMPTY_LEVEL    = 3'd2,
		REG_TYPE_STANDARD  = 3'd3,
		REG_TYPE_SECOND    = 3'd4,
		REG_TYPE_THIRD     = 3'd5,
		REG_QUALITY_GOOD   = 3'd6,
		REG_QUALITY_USABLE = 3'd7
	} cfg_idx_e;

	typedef enum logic [1:0] {
		LVL_ZERO = 2'd0,
		LVL_FULL = 2'd1,
		LVL_DIV  = 2'd2
	} lvl_mode_e;

	typedef struct packed {
		logic [AddrW-1:0] sender_address;
		logic [3:0]       record_count;
		logic [7:0]       payload_length;
		logic [7:0]       type_byte;
		logic [7:0]       battery_byte;
		logic [7:0]       temperature_byte;
		logic [7:0]       distance_low_byte;
		logic [7:0]       distance_high_byte;
	} in_t;

	typedef struct packed {
		status_e            status;
		logic [PctW-1:0]    battery_percent;
		logic [MmW-1:0]     distance_mm;
		logic [1:0]         read_quality;
		logic               poor_quality;
		logic [PctW-1:0]    tank_level_percent;
		logic signed [7:0]  temperature_c;
	} res_t;

	typedef struct packed {
		logic [AddrW-1:0] device_address;
		logic [MmW-1:0]   full_level_mm;
		logic [MmW-1:0]   empty_level_mm;
		logic [7:0]       type_code_standard;
		logic [7:0]       type_code_second;
		logic [7:0]       type_code_third;
		logic [1:0]       quality_good_min;
		logic [1:0]       quality_usable_min;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		device_address:     48'd0,
		full_level_mm:      14'd1000,
		empty_level_mm:     14'd0,
		type_code_standard: 8'd3,
		type_code_second:   8'd6,
		type_code_third:    8'd8,
		quality_good_min:   2'd3,
		quality_usable_min: 2'd2
	};

	// front stage output
	typedef struct packed {
		status_e           status;
		logic [MmW-1:0]    bat_x;
		logic signed [7:0] temp;
		logic [1:0]        quality;
		logic              poor;
		logic              unusable;
		logic [MmW-1:0]    raw;
		logic [MmW-1:0]    tt;
		logic [22:0]       m1;
	} front_t;

	// divider stage contents
	typedef struct packed {
		res_t              res;
		lvl_mode_e         mode;
		logic [NumW-1:0]   rem;
		logic [MmW-1:0]    den;
		logic [QuoW-1:0]   quo;
	} div_t;

endpackage

`default_nettype wire

FILE: sv/tank_level_advert_decoder.sv
// top level of the tank level advert decoder: configuration registers and the pipeline
// depends on tlad_pkg, tlad_front, tlad_core, tlad_div and assert_macros.svh
//
// Usage:
//   An advert transaction is taken at each rising edge where start is high and busy
//   is low. busy never rises, so one advert can be taken in every cycle.
//   The result of an advert is accepted when it leaves the last register stage:
//   done is high for one cycle and result holds its status and
//   readings; results leave in the order adverts came in.
//   There is one register stage per step: checks, polynomial, distance
//   product, level setup, three divider stages of two quotient bits each and a last
//   stage that takes the final quotient bit and formats the result. Every stage
//   takes a new advert each cycle, so throughput is one advert per cycle.
//   The receiver cannot stall; each result is shown for exactly one cycle.
//   Configuration: a transaction on cfg_valid/cfg_ready writes register cfg_index
//   with cfg_data; cfg_ready is always high. The user must change registers only
//   while no advert is in flight; the block itself does not enforce this.
//   Reset (arst_n low) clears all valid bits at once and loads the register
//   defaults; no result appears for adverts that were in flight.
`default_nettype none

module tank_level_advert_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire tlad_pkg::in_t                 item,
	output logic                               done,
	output tlad_pkg::res_t                     result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tlad_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [tlad_pkg::AddrW-1:0]    cfg_data
);
	import tlad_pkg::*;

	`include "assert_macros.svh"

	cfg_t   cfg_q;
	logic   accept;
	logic   valid_s1, valid_s4;
	front_t front_s1;
	div_t   div_s4;
	logic   rejected_dirty;
	logic   unusable_dist;
	logic   pct_over;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_e'(cfg_index))
				REG_DEVICE_ADDRESS: cfg_q.device_address     <= cfg_data;
				REG_FULL_LEVEL:     cfg_q.full_level_mm      <= cfg_data[MmW-1:0];
				REG_EMPTY_LEVEL:    cfg_q.empty_level_mm     <= cfg_data[MmW-1:0];
				REG_TYPE_STANDARD:  cfg_q.type_code_standard <= cfg_data[7:0];
				REG_TYPE_SECOND:    cfg_q.type_code_second   <= cfg_data[7:0];
				REG_TYPE_THIRD:     cfg_q.type_code_third    <= cfg_data[7:0];
				REG_QUALITY_GOOD:   cfg_q.quality_good_min   <= cfg_data[1:0];
				REG_QUALITY_USABLE: cfg_q.quality_usable_min <= cfg_data[1:0];
				default:            cfg_q                    <= cfg_q;
			endcase
		end
	end

	tlad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.front_s1 (front_s1)
	);

	tlad_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.front_s1 (front_s1),
		.valid_s4 (valid_s4),
		.div_s4   (div_s4)
	);

	tlad_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s4  (valid_s4),
		.div_s4    (div_s4),
		.done_s8   (done),
		.result_s8 (result)
	);

	assign rejected_dirty = done && result.status != ST_OK &&
		(result.battery_percent != '0 || result.distance_mm != '0 ||
		result.tank_level_percent != '0 || result.temperature_c != '0);
	assign unusable_dist  = done && result.status == ST_OK &&
		result.read_quality < cfg_q.quality_usable_min && result.distance_mm != '0;
	assign pct_over       = done &&
		(result.tank_level_percent > PCT_FULL || result.battery_percent > PCT_FULL);

	`ASSERT_PROP(a_latency, clk, arst_n, accept |-> ##8 done, "result missing after advert")
	`ASSERT_NEVER(a_reject_clear, clk, arst_n, rejected_dirty, "rejected advert carries readings")
	`ASSERT_NEVER(a_unusable_zero, clk, arst_n, unusable_dist, "unusable reading has distance")
	`ASSERT_NEVER(a_pct_range, clk, arst_n, pct_over, "percent above full scale")

endmodule

`default_nettype wire

FILE: sv/tlad_front.sv
// first stage: advert checks, battery scaling, temperature and polynomial products
// depends on tlad_pkg
`default_nettype none

module tlad_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire tlad_pkg::in_t  item,
	input  wire tlad_pkg::cfg_t cfg,
	output logic                valid_s1,
	output tlad_pkg::front_t    front_s1
);
	import tlad_pkg::*;

	front_t     nxt;
	logic [6:0] v;
	logic [6:0] t;
	logic [10:0] ten_v;
	logic [10:0] bat_diff;

	always_comb begin
		v        = item.battery_byte[6:0];
		t        = item.temperature_byte[6:0];
		ten_v    = {1'b0, v, 3'b000} + {3'b000, v, 1'b0};
		bat_diff = ten_v - BAT_OFFSET;

		if (item.sender_address != cfg.device_address) begin
			nxt.status = ST_ADDR;
		end else if (item.record_count != RECORDS_OK) begin
			nxt.status = ST_COUNT;
		end else if (item.payload_length != PAYLOAD_BYTES) begin
			nxt.status = ST_LEN;
		end else if (item.type_byte != cfg.type_code_standard &&
				item.type_byte != cfg.type_code_second &&
				item.type_byte != cfg.type_code_third) begin
			nxt.status = ST_TYPE;
		end else begin
			nxt.status = ST_OK;
		end

		if (ten_v <= BAT_OFFSET) begin
			nxt.bat_x = '0;
		end else begin
			nxt.bat_x = MmW'(bat_diff) * BAT_SCALE;
		end

		nxt.temp     = $signed(8'({1'b0, t}) - TEMP_OFFSET);
		nxt.quality  = item.distance_high_byte[7:6];
		nxt.poor     = (item.distance_high_byte[7:6] < cfg.quality_good_min);
		nxt.unusable = (item.distance_high_byte[7:6] < cfg.quality_usable_min);
		nxt.raw      = {item.distance_high_byte[5:0], item.distance_low_byte};
		nxt.tt       = MmW'(t) * MmW'(t);
		nxt.m1       = 23'(t) * COEF_C1_MAG;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

FILE: sv/tlad_core.sv
// stages two to four: battery percent, polynomial, distance product, quality gate and level setup
// depends on tlad_pkg
`default_nettype none

module tlad_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tlad_pkg::cfg_t   cfg,
	input  wire logic             valid_s1,
	input  wire tlad_pkg::front_t front_s1,
	output logic                  valid_s4,
	output tlad_pkg::div_t        div_s4
);
	import tlad_pkg::*;

	typedef struct packed {
		status_e           status;
		logic [PctW-1:0]   battery;
		logic signed [7:0] temp;
		logic [1:0]        quality;
		logic              poor;
		logic              unusable;
		logic [MmW-1:0]    raw;
	} side_t;

	side_t            side_s2, side_s3;
	logic [PolyW-1:0] poly_s2;
	logic [37:0]      prod_s3;
	logic             valid_s2, valid_s3;

	logic [28:0]      bat_prod;
	logic [8:0]       bat_p;
	logic [PolyW:0]   poly_wide;
	logic [MmW-1:0]   dist_mm;
	div_t             nxt4;

	// battery percent and temperature polynomial
	always_comb begin
		bat_prod  = 29'(front_s1.bat_x) * BAT_RECIP;
		bat_p     = bat_prod[BAT_SHIFT +: 9];
		poly_wide = COEF_C0 - 25'(front_s1.m1) - 25'(front_s1.tt) * COEF_C2_MAG;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			side_s2.status   <= front_s1.status;
			side_s2.battery  <= (bat_p > 9'(PCT_FULL)) ? PCT_FULL : bat_p[PctW-1:0];
			side_s2.temp     <= front_s1.temp;
			side_s2.quality  <= front_s1.quality;
			side_s2.poor     <= front_s1.poor;
			side_s2.unusable <= front_s1.unusable;
			side_s2.raw      <= front_s1.raw;
			poly_s2          <= poly_wide[PolyW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			side_s3 <= side_s2;
			prod_s3 <= 38'(side_s2.raw) * 38'(poly_s2);
		end
	end

	// quality gate and fill level classification
	always_comb begin
		dist_mm = side_s3.unusable ? '0 : prod_s3[37:24];
		nxt4.res.status             = side_s3.status;
		nxt4.res.battery_percent    = side_s3.battery;
		nxt4.res.distance_mm        = dist_mm;
		nxt4.res.read_quality       = side_s3.quality;
		nxt4.res.poor_quality       = side_s3.poor;
		nxt4.res.tank_level_percent = '0;
		nxt4.res.temperature_c      = side_s3.temp;
		if (dist_mm >= cfg.full_level_mm) begin
			nxt4.mode = LVL_FULL;
		end else if (dist_mm > cfg.empty_level_mm) begin
			nxt4.mode = LVL_DIV;
		end else begin
			nxt4.mode = LVL_ZERO;
		end
		nxt4.rem = NumW'(dist_mm - cfg.empty_level_mm) * LEVEL_SCALE;
		nxt4.den = cfg.full_level_mm - cfg.empty_level_mm;
		nxt4.quo = '0;
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			div_s4 <= nxt4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

endmodule

`default_nettype wire

FILE: sv/tlad_div.sv
// stages five to eight: pipelined restoring divider for the fill level and result register
// depends on tlad_pkg
`default_nettype none

module tlad_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid_s4,
	input  wire tlad_pkg::div_t div_s4,
	output logic                done_s8,
	output tlad_pkg::res_t      result_s8
);
	import tlad_pkg::*;

	div_t st_s5, st_s6, st_s7;
	logic valid_s5, valid_s6, valid_s7;
	div_t last;
	res_t res_nxt;

	// one quotient bit: subtract the shifted divisor when it fits
	function automatic div_t div_bit(input div_t x, input int k);
		div_t            y;
		logic [NumW-1:0] dsh;
		y   = x;
		dsh = NumW'(x.den) << k;
		if (x.rem >= dsh) begin
			y.rem              = x.rem - dsh;
			y.quo[k[2:0]]      = 1'b1;
		end
		return y;
	endfunction

	function automatic div_t div_pair(input div_t x, input int k);
		div_t y;
		y = div_bit(x, k);
		y = div_bit(y, k - 1);
		return y;
	endfunction

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			st_s5 <= div_pair(div_s4, 6);
		end
		if (valid_s5) begin
			st_s6 <= div_pair(st_s5, 4);
		end
		if (valid_s6) begin
			st_s7 <= div_pair(st_s6, 2);
		end
	end

	always_comb begin
		last    = div_bit(st_s7, 0);
		res_nxt = last.res;
		case (last.mode)
			LVL_FULL: res_nxt.tank_level_percent = PCT_FULL;
			LVL_DIV:  res_nxt.tank_level_percent = last.quo;
			default:  res_nxt.tank_level_percent = '0;
		endcase
		// rejected advert reports only its status
		if (last.res.status != ST_OK) begin
			res_nxt        = '0;
			res_nxt.status = last.res.status;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s7) begin
			result_s8 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			done_s8  <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			done_s8  <= valid_s7;
		end
	end

endmodule

`default_nettype wire
